FILE: sv/pbr_pkg.sv
package pbr_pkg;

    // palette depth, 2 to 256 entries
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;

    // brightness step codes
    localparam logic [2:0] LVL_DIM75  = 3'd1;
    localparam logic [2:0] LVL_DIM90  = 3'd2;
    localparam logic [2:0] LVL_UNITY  = 3'd3;
    localparam logic [2:0] LVL_BRT120 = 3'd4;
    localparam logic [2:0] LVL_BRT130 = 3'd5;

    // only distances below this qualify
    localparam logic [6:0] DIST_LIMIT = 7'd100;

    // floor(x / 10) == (x * RECIP10) >> RECIP10_SH for x below 4096
    localparam logic [15:0] RECIP10    = 16'd52429;
    localparam int          RECIP10_SH = 19;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_SEARCH,
        OP_PASS
    } t_op;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // one item travelling down the row of cells
    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [7:0]        pix;
        logic [7:0]        widx;
        t_rgb              color;
        logic [6:0]        best_d;
        logic [PAL_AW-1:0] best_i;
        logic              found;
    } t_item;

endpackage

FILE: sv/pbr_front.sv
module pbr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_accept,
    input  logic          i_cmd,
    input  logic [7:0]    i_entry_index,
    input  logic [7:0]    i_entry_red,
    input  logic [7:0]    i_entry_green,
    input  logic [7:0]    i_entry_blue,
    input  logic [7:0]    i_pixel_in,
    input  logic [2:0]    i_level,
    output pbr_pkg::t_item o_item
);
    import pbr_pkg::*;

    function automatic logic [11:0] scale_num(input logic [7:0] c, input logic [2:0] lv);
        logic [11:0] x;
        begin
            x = 12'(c);
            unique case (lv)
                LVL_DIM75:  scale_num = 12'((x << 1) + x);
                LVL_DIM90:  scale_num = 12'((x << 3) + x);
                LVL_BRT120: scale_num = 12'((x << 3) + (x << 2));
                LVL_BRT130: scale_num = 12'((x << 3) + (x << 2) + x);
                default:    scale_num = x;
            endcase
        end
    endfunction

    function automatic logic [7:0] scale_div(input logic [11:0] num, input logic [2:0] lv);
        logic [27:0] prod;
        logic [8:0]  v;
        begin
            prod = 28'(num) * 28'(RECIP10);
            if (lv == LVL_DIM75) begin
                v = 9'(num >> 2);
            end else begin
                v = prod[RECIP10_SH +: 9];
            end
            // fold back above full scale
            if (v > 9'd255) begin
                v = 9'd510 - v;
            end
            scale_div = v[7:0];
        end
    endfunction

    logic [23:0]       mem [PAL_ENTRIES];
    logic              wr_in_range;
    logic              rd_in_range;
    t_op               in_op;

    logic              r_a_valid;
    t_op               r_a_op;
    logic [7:0]        r_a_pix;
    logic [7:0]        r_a_widx;
    t_rgb              r_a_col;
    logic              r_a_inrange;
    logic [23:0]       r_rd;

    logic              r_b_valid;
    t_op               r_b_op;
    logic [7:0]        r_b_pix;
    logic [7:0]        r_b_widx;
    t_rgb              r_b_col;
    logic [11:0]       r_b_num_r;
    logic [11:0]       r_b_num_g;
    logic [11:0]       r_b_num_b;

    t_item             r_c_item;
    t_rgb              rd_col;
    t_rgb              n_scaled;

    assign wr_in_range = 9'(i_entry_index) < 9'(PAL_ENTRIES);
    assign rd_in_range = 9'(i_pixel_in) < 9'(PAL_ENTRIES);

    always_comb begin
        if (!i_cmd) begin
            in_op = OP_WRITE;
        end else if (i_level == LVL_DIM75 || i_level == LVL_DIM90 ||
                     i_level == LVL_BRT120 || i_level == LVL_BRT130) begin
            in_op = OP_SEARCH;
        end else begin
            in_op = OP_PASS;
        end
    end

    // color lookup copy of the palette
    always_ff @(posedge i_clk) begin
        if (i_adv && i_accept && !i_cmd && wr_in_range) begin
            mem[i_entry_index[PAL_AW-1:0]] <= {i_entry_red, i_entry_green, i_entry_blue};
        end
        if (i_adv) begin
            r_rd <= mem[i_pixel_in[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid   <= i_accept;
            r_a_op      <= in_op;
            r_a_pix     <= i_pixel_in;
            r_a_widx    <= i_entry_index;
            r_a_col     <= '{red: i_entry_red, green: i_entry_green, blue: i_entry_blue};
            r_a_inrange <= rd_in_range;
        end
    end

    // out-of-range pixel reads black
    assign rd_col = r_a_inrange ? t_rgb'(r_rd) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_adv) begin
            r_b_valid <= r_a_valid;
            r_b_op    <= r_a_op;
            r_b_pix   <= r_a_pix;
            r_b_widx  <= r_a_widx;
            r_b_col   <= r_a_col;
            r_b_num_r <= scale_num(rd_col.red, i_level);
            r_b_num_g <= scale_num(rd_col.green, i_level);
            r_b_num_b <= scale_num(rd_col.blue, i_level);
        end
    end

    assign n_scaled.red   = scale_div(r_b_num_r, i_level);
    assign n_scaled.green = scale_div(r_b_num_g, i_level);
    assign n_scaled.blue  = scale_div(r_b_num_b, i_level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_item.valid <= 1'b0;
        end else if (i_adv) begin
            r_c_item.valid  <= r_b_valid;
            r_c_item.op     <= r_b_op;
            r_c_item.pix    <= r_b_pix;
            r_c_item.widx   <= r_b_widx;
            r_c_item.color  <= (r_b_op == OP_SEARCH) ? n_scaled : r_b_col;
            r_c_item.best_d <= DIST_LIMIT;
            r_c_item.best_i <= '0;
            r_c_item.found  <= 1'b0;
        end
    end

    assign o_item = r_c_item;

endmodule

FILE: sv/pbr_cell.sv
module pbr_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic [pbr_pkg::PAL_AW-1:0] i_cell_idx,
    input  pbr_pkg::t_item             i_item,
    output pbr_pkg::t_item             o_item
);
    import pbr_pkg::*;

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        begin
            absdiff = (a > b) ? a - b : b - a;
        end
    endfunction

    t_rgb        r_color;
    t_item       r_item;
    t_item       n_item;
    logic [9:0]  l1_d;
    logic        hit;
    logic        own;

    assign own  = 9'(i_cell_idx) == 9'(i_item.widx);
    assign l1_d = 10'(absdiff(i_item.color.red, r_color.red))
                + 10'(absdiff(i_item.color.green, r_color.green))
                + 10'(absdiff(i_item.color.blue, r_color.blue));
    // strict compare keeps the lowest index on a tie
    assign hit  = (i_item.op == OP_SEARCH) && (l1_d < 10'(i_item.best_d));

    always_comb begin
        n_item = i_item;
        if (hit) begin
            n_item.best_d = l1_d[6:0];
            n_item.best_i = i_cell_idx;
            n_item.found  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_item.valid && i_item.op == OP_WRITE && own) begin
            r_color <= i_item.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

FILE: sv/palette_brightness_remap.sv
// channel   direction  handshake                 payload
// input     in         i_valid / o_stall         i_cmd, i_entry_index, i_entry_red/green/blue,
//                                                i_pixel_in
// result    out        o_valid / i_stall         o_pixel_out, o_no_match
// config    in         i_cfg_valid / o_cfg_ready i_cfg_data (level)
//
// one item enters per cycle while the result side moves; between an item and its
// result lie three front stages (palette lookup, scale multiply, divide and
// fold), one register per palette cell and one output register
// reset clears the valid bits of every stage and sets level to unchanged
// a stalled result freezes the whole row, and o_stall is then raised to the input
module palette_brightness_remap (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_entry_index,
    input  logic [7:0] i_entry_red,
    input  logic [7:0] i_entry_green,
    input  logic [7:0] i_entry_blue,
    input  logic [7:0] i_pixel_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_pixel_out,
    output logic       o_no_match,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_data
);
    import pbr_pkg::*;

    logic       adv;
    logic       accept;
    logic [2:0] r_level;
    logic       r_out_valid;
    logic [7:0] r_out_pix;
    logic       r_out_nm;
    t_item      chain [PAL_ENTRIES+1];
    t_item      last;

    // whole row moves unless a finished result is held
    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;
    assign accept  = i_valid && adv;

    // config port never pushes back
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LVL_UNITY;
        end else if (i_cfg_valid) begin
            r_level <= i_cfg_data;
        end
    end

    // lookup and scaling in front of the row
    pbr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_accept      (accept),
        .i_cmd         (i_cmd),
        .i_entry_index (i_entry_index),
        .i_entry_red   (i_entry_red),
        .i_entry_green (i_entry_green),
        .i_entry_blue  (i_entry_blue),
        .i_pixel_in    (i_pixel_in),
        .i_level       (r_level),
        .o_item        (chain[0])
    );

    // one cell per palette entry; writes and searches flow in arrival order,
    // so every search sees exactly the writes accepted before it
    for (genvar k = 0; k < PAL_ENTRIES; k++) begin : g_cell
        pbr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (adv),
            .i_cell_idx (PAL_AW'(k)),
            .i_item     (chain[k]),
            .o_item     (chain[k+1])
        );
    end

    assign last = chain[PAL_ENTRIES];

    // palette writes give no result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= last.valid && (last.op != OP_WRITE);
            r_out_pix   <= (last.op == OP_SEARCH && last.found) ? 8'(last.best_i) : last.pix;
            r_out_nm    <= (last.op == OP_SEARCH) && !last.found;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_pix;
    assign o_no_match  = r_out_nm;

endmodule
